>>> hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared constants, codes and types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  localparam int MaxKnots = 64;
  localparam int IdxW     = $clog2(MaxKnots);
  localparam int CntW     = IdxW + 1;
  localparam int DataW    = 32;
  localparam int FracBits = 16;
  localparam int OpW      = DataW + 1;
  localparam int ProdW    = 2 * OpW;
  localparam int MulSteps = OpW;
  localparam int DivSteps = ProdW;
  localparam int StepW    = $clog2(DivSteps + 1);

  localparam logic [DataW-1:0] ClampLowReset  = DataW'((1 << FracBits) / 100);
  localparam logic [DataW-1:0] ClampHighReset = DataW'(2 << FracBits);

  localparam logic [1:0] ModeFlat   = 2'd0;
  localparam logic [1:0] ModeLinear = 2'd1;
  localparam logic [1:0] ModeClamp  = 2'd2;

  localparam logic [1:0] RegExtrapMode = 2'd0;
  localparam logic [1:0] RegKnotCount  = 2'd1;
  localparam logic [1:0] RegClampLow   = 2'd2;
  localparam logic [1:0] RegClampHigh  = 2'd3;

  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusWritten   = 2'd1;
  localparam logic [1:0] StatusZeroWidth = 2'd2;

  localparam logic [1:0] RegionInside = 2'd0;
  localparam logic [1:0] RegionBelow  = 2'd1;
  localparam logic [1:0] RegionAbove  = 2'd2;

  localparam logic ReqWrite = 1'b0;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_RD_FIRST, S_RD_LAST, S_REGION, S_SADDR, S_SCMP,
    S_K0, S_K1, S_K2, S_PREP, S_MUL, S_DIV, S_DONE
  } state_t;

  typedef enum logic [2:0] {A_FIRST, A_LAST, A_MID, A_K, A_K1} addr_sel_t;

  typedef struct packed {
    logic      accept;
    logic      ram_we;
    addr_sel_t addr_sel;
    logic      cap_first;
    logic      region_set;
    logic      search_cmp;
    logic      k_latch;
    logic      cap_lo;
    logic      cap_hi;
    logic      prep;
    logic      mul_step;
    logic      div_step;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic zero_width;
    logic out_free;
  } status_t;

endpackage

>>> hw/rtl/pli_ram.sv
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Config registers, knot tables, search, serial multiply/divide, output stage.
// ----------------------------------------------------------------------------
module pli_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  pli_pkg::cmd_t                cmd,
  output pli_pkg::status_t             st,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [pli_pkg::DataW-1:0]    cfg_data,
  input  logic                         req_type,
  input  logic [pli_pkg::IdxW-1:0]     knot_index,
  input  logic signed [pli_pkg::DataW-1:0] knot_x,
  input  logic signed [pli_pkg::DataW-1:0] knot_y,
  input  logic signed [pli_pkg::DataW-1:0] query_x,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [pli_pkg::DataW-1:0] result_y,
  output logic [pli_pkg::IdxW-1:0]     interval,
  output logic [1:0]                   region,
  output logic                         saturated,
  output logic [1:0]                   status
);
  import pli_pkg::*;

  localparam logic signed [DataW+3:0] SatMax = {5'b00000, {(DataW-1){1'b1}}};
  localparam logic signed [DataW+3:0] SatMin = {5'b11111, {(DataW-1){1'b0}}};

  logic [1:0]              mode;
  logic [CntW-1:0]         knot_count;
  logic signed [DataW-1:0] clamp_low, clamp_high;

  logic                    req_r;
  logic [IdxW-1:0]         kidx_r;
  logic signed [DataW-1:0] kx_r, ky_r, qx_r;

  logic signed [DataW-1:0] rdata_x, rdata_y;
  logic [IdxW-1:0]         raddr;

  logic signed [DataW-1:0] xfirst, v_r, e_r, x0_r, x1_r, y0_r, y1_r;
  logic [1:0]              region_r;
  logic [CntW-1:0]         lo, cnt, n_eff, mid, kk, n_m2;
  logic [IdxW-1:0]         k_r, last_idx, k_comb;

  logic [OpW-1:0]          mcand, divisor, rem;
  logic [ProdW-1:0]        prod;
  logic                    neg;

  logic signed [OpW-1:0]   da, db, dc;
  logic [OpW:0]            msum;
  logic [OpW:0]            sh;
  logic                    ge;
  logic                    below, above, flat;

  logic                    big;
  logic signed [OpW+1:0]   qs;
  logic signed [DataW+3:0] sum;
  logic signed [DataW-1:0] res;
  logic                    sat;
  logic                    out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= ModeClamp;
      knot_count <= CntW'(2);
      clamp_low  <= ClampLowReset;
      clamp_high <= ClampHighReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegExtrapMode: mode       <= cfg_data[1:0];
        RegKnotCount:  knot_count <= cfg_data[CntW-1:0];
        RegClampLow:   clamp_low  <= cfg_data;
        RegClampHigh:  clamp_high <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (knot_count < CntW'(2)) begin
      n_eff = CntW'(2);
    end else if (knot_count > CntW'(MaxKnots)) begin
      n_eff = CntW'(MaxKnots);
    end else begin
      n_eff = knot_count;
    end
  end

  assign last_idx = IdxW'(n_eff - CntW'(1));
  assign n_m2     = n_eff - CntW'(2);
  assign mid      = lo + (cnt >> 1);

  always_comb begin
    kk = (lo == '0) ? '0 : lo - CntW'(1);
    if (kk > n_m2) begin
      kk = n_m2;
    end
    k_comb = kk[IdxW-1:0];
  end

  always_comb begin
    unique case (cmd.addr_sel)
      A_FIRST: raddr = '0;
      A_LAST:  raddr = last_idx;
      A_MID:   raddr = mid[IdxW-1:0];
      A_K:     raddr = k_comb;
      A_K1:    raddr = k_r + IdxW'(1);
      default: raddr = '0;
    endcase
  end

  pli_ram #(.Width(DataW), .Depth(MaxKnots)) u_xram (
    .clk, .we(cmd.ram_we), .waddr(kidx_r), .wdata(kx_r), .raddr, .rdata(rdata_x)
  );

  pli_ram #(.Width(DataW), .Depth(MaxKnots)) u_yram (
    .clk, .we(cmd.ram_we), .waddr(kidx_r), .wdata(ky_r), .raddr, .rdata(rdata_y)
  );

  assign below = qx_r < xfirst;
  assign above = qx_r > rdata_x;
  assign flat  = (mode == ModeFlat);

  assign da = {y1_r[DataW-1], y1_r} - {y0_r[DataW-1], y0_r};
  assign db = {e_r[DataW-1], e_r} - {x0_r[DataW-1], x0_r};
  assign dc = {x1_r[DataW-1], x1_r} - {x0_r[DataW-1], x0_r};

  assign msum = {1'b0, prod[ProdW-1:OpW]} + (prod[0] ? {1'b0, mcand} : '0);
  assign sh   = {rem, prod[ProdW-1]};
  assign ge   = sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= req_type;
      kidx_r <= knot_index;
      kx_r   <= knot_x;
      ky_r   <= knot_y;
      qx_r   <= query_x;
    end
    if (cmd.cap_first) begin
      xfirst <= rdata_x;
    end
    if (cmd.region_set) begin
      lo  <= '0;
      cnt <= n_eff;
      if (below) begin
        region_r <= RegionBelow;
        v_r      <= xfirst;
        e_r      <= flat ? xfirst : qx_r;
      end else if (above) begin
        region_r <= RegionAbove;
        v_r      <= rdata_x;
        e_r      <= flat ? rdata_x : qx_r;
      end else begin
        region_r <= RegionInside;
        v_r      <= qx_r;
        e_r      <= qx_r;
      end
    end
    if (cmd.search_cmp) begin
      if (!(v_r < rdata_x)) begin
        lo  <= mid + CntW'(1);
        cnt <= cnt - (cnt >> 1) - CntW'(1);
      end else begin
        cnt <= cnt >> 1;
      end
    end
    if (cmd.k_latch) begin
      k_r <= k_comb;
    end
    if (cmd.cap_lo) begin
      x0_r <= rdata_x;
      y0_r <= rdata_y;
    end
    if (cmd.cap_hi) begin
      x1_r <= rdata_x;
      y1_r <= rdata_y;
    end
    if (cmd.prep) begin
      mcand   <= da[OpW-1] ? OpW'(-da) : OpW'(da);
      divisor <= dc[OpW-1] ? OpW'(-dc) : OpW'(dc);
      prod    <= {OpW'(0), (db[OpW-1] ? OpW'(-db) : OpW'(db))};
      rem     <= '0;
      neg     <= da[OpW-1] ^ db[OpW-1] ^ dc[OpW-1];
    end
    if (cmd.mul_step) begin
      prod <= {msum, prod[OpW-1:1]};
    end
    if (cmd.div_step) begin
      rem  <= ge ? OpW'(sh - {1'b0, divisor}) : sh[OpW-1:0];
      prod <= {prod[ProdW-2:0], ge};
    end
  end

  always_comb begin
    big = |prod[ProdW-1:OpW+1];
    qs  = neg ? -$signed({1'b0, prod[OpW:0]}) : $signed({1'b0, prod[OpW:0]});
    sum = $signed({{4{y0_r[DataW-1]}}, y0_r}) + (DataW+4)'(qs);
    sat = 1'b0;
    if (big) begin
      sat = 1'b1;
      res = neg ? DataW'(SatMin) : DataW'(SatMax);
    end else if (sum > SatMax) begin
      sat = 1'b1;
      res = DataW'(SatMax);
    end else if (sum < SatMin) begin
      sat = 1'b1;
      res = DataW'(SatMin);
    end else begin
      res = sum[DataW-1:0];
    end
    if (region_r != RegionInside && mode >= ModeClamp) begin
      if (res < clamp_low) begin
        res = clamp_low;
        sat = 1'b1;
      end
      if (res > clamp_high) begin
        res = clamp_high;
        sat = 1'b1;
      end
    end
  end

  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (req_r == ReqWrite) begin
        result_y  <= '0;
        interval  <= kidx_r;
        region    <= RegionInside;
        saturated <= 1'b0;
        status    <= StatusWritten;
      end else if (x1_r == x0_r) begin
        result_y  <= y1_r;
        interval  <= k_r;
        region    <= region_r;
        saturated <= 1'b0;
        status    <= StatusZeroWidth;
      end else begin
        result_y  <= res;
        interval  <= k_r;
        region    <= region_r;
        saturated <= sat;
        status    <= StatusOk;
      end
    end
  end

  assign st.cnt_zero   = (cnt == '0);
  assign st.zero_width = (x1_r == x0_r);
  assign st.out_free   = !out_valid || !out_stall;

endmodule

>>> hw/rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for knot writes and queries: search, fetch, multiply, divide.
// ----------------------------------------------------------------------------
module pli_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  input  pli_pkg::status_t st,
  output pli_pkg::cmd_t    cmd
);
  import pli_pkg::*;

  state_t           state, state_next;
  logic [StepW-1:0] step_cnt, step_cnt_next;
  logic             mul_last, div_last;

  assign mul_last = (step_cnt == StepW'(MulSteps - 1));
  assign div_last = (step_cnt == StepW'(DivSteps - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) begin
                    state_next = (req_type == ReqWrite) ? S_WRITE : S_RD_FIRST;
                  end
      S_WRITE:    state_next = S_DONE;
      S_RD_FIRST: state_next = S_RD_LAST;
      S_RD_LAST:  state_next = S_REGION;
      S_REGION:   state_next = S_SADDR;
      S_SADDR:    state_next = st.cnt_zero ? S_K0 : S_SCMP;
      S_SCMP:     state_next = S_SADDR;
      S_K0:       state_next = S_K1;
      S_K1:       state_next = S_K2;
      S_K2:       state_next = S_PREP;
      S_PREP:     state_next = st.zero_width ? S_DONE : S_MUL;
      S_MUL:      if (mul_last) begin
                    state_next = S_DIV;
                  end
      S_DIV:      if (div_last) begin
                    state_next = S_DONE;
                  end
      S_DONE:     if (st.out_free) begin
                    state_next = S_IDLE;
                  end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    step_cnt_next = '0;
    if ((state == S_MUL && !mul_last) || (state == S_DIV && !div_last)) begin
      step_cnt_next = step_cnt + StepW'(1);
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.addr_sel = A_FIRST;
    in_stall     = (state != S_IDLE);
    unique case (state)
      S_IDLE:     cmd.accept = in_valid;
      S_WRITE:    cmd.ram_we = 1'b1;
      S_RD_FIRST: cmd.addr_sel = A_FIRST;
      S_RD_LAST:  begin
                    cmd.addr_sel  = A_LAST;
                    cmd.cap_first = 1'b1;
                  end
      S_REGION:   cmd.region_set = 1'b1;
      S_SADDR:    cmd.addr_sel = A_MID;
      S_SCMP:     cmd.search_cmp = 1'b1;
      S_K0:       begin
                    cmd.addr_sel = A_K;
                    cmd.k_latch  = 1'b1;
                  end
      S_K1:       begin
                    cmd.addr_sel = A_K1;
                    cmd.cap_lo   = 1'b1;
                  end
      S_K2:       cmd.cap_hi = 1'b1;
      S_PREP:     cmd.prep = 1'b1;
      S_MUL:      cmd.mul_step = 1'b1;
      S_DIV:      cmd.div_step = 1'b1;
      S_DONE:     cmd.out_load = st.out_free;
      default:    ;
    endcase
  end

  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> step_cnt < StepW'(MulSteps))
    else $error("multiply step count out of range");

  a_done_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && st.out_free) |=> state == S_IDLE)
    else $error("result load did not return to idle");

  a_mul_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREP && !st.zero_width) |=> (state == S_MUL && step_cnt == '0))
    else $error("multiply did not start clean");

  a_accept_leaves: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> state != S_IDLE)
    else $error("accepted item left controller idle");

endmodule

>>> hw/rtl/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Knot table with binary-search piecewise linear interpolation, Q16.16.
// ----------------------------------------------------------------------------
// One item is processed at a time. A knot write passes through accept, table
// write and result load. A query passes through accept, the read of the end
// knots and the region decision, a binary search of 1 to 7 steps (up to 7 for
// 64 knots) closed by a last address step, the fetch of the interval, a
// bit-serial 33-step multiply, a 66-step restoring divide and the result load.
// A zero-width interval skips multiply and divide. The result sits in an
// output register, so the block is free for the next item as soon as the
// result is loaded; a result still stalled at the output holds the block in
// its load state, and with it the input.
module piecewise_linear_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [pli_pkg::DataW-1:0]        cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             req_type,
  input  logic [pli_pkg::IdxW-1:0]         knot_index,
  input  logic signed [pli_pkg::DataW-1:0] knot_x,
  input  logic signed [pli_pkg::DataW-1:0] knot_y,
  input  logic signed [pli_pkg::DataW-1:0] query_x,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [pli_pkg::DataW-1:0] result_y,
  output logic [pli_pkg::IdxW-1:0]         interval,
  output logic [1:0]                       region,
  output logic                             saturated,
  output logic [1:0]                       status
);
  import pli_pkg::*;

  cmd_t    cmd;
  status_t st;

  pli_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .req_type, .st, .cmd
  );

  pli_datapath u_dp (
    .clk, .rst, .cmd, .st, .cfg_we, .cfg_index, .cfg_data,
    .req_type, .knot_index, .knot_x, .knot_y, .query_x,
    .out_valid, .out_stall, .result_y, .interval, .region, .saturated, .status
  );

endmodule

>>> tb/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Watches the register port and both item channels of the interpolator,
// keeps its own copy of the knot table and registers, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module pli_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [1:0]                       cfg_index,
  input  logic [pli_pkg::DataW-1:0]        cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             req_type,
  input  logic [pli_pkg::IdxW-1:0]         knot_index,
  input  logic signed [pli_pkg::DataW-1:0] knot_x,
  input  logic signed [pli_pkg::DataW-1:0] knot_y,
  input  logic signed [pli_pkg::DataW-1:0] query_x,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [pli_pkg::DataW-1:0] result_y,
  input  logic [pli_pkg::IdxW-1:0]         interval,
  input  logic [1:0]                       region,
  input  logic                             saturated,
  input  logic [1:0]                       status,
  output int                               errors,
  output int                               pending,
  output int                               n_queries,
  output int                               n_outside,
  output int                               n_zero_width
);
  import pli_pkg::*;

  localparam logic [63:0] QuotCap = 64'd1 << 41;

  typedef struct packed {
    logic [DataW-1:0] y;
    logic [IdxW-1:0]  ivl;
    logic [1:0]       reg_code;
    logic             sat;
    logic [1:0]       st;
  } interp_result_t;

  interp_result_t result_q[$];
  longint         knot_xs[MaxKnots];
  longint         knot_ys[MaxKnots];
  logic [1:0]     mode_r;
  logic [6:0]     count_r;
  longint         clamp_lo_r;
  longint         clamp_hi_r;

  function automatic longint scaled_quotient(longint a, longint b, longint c);
    logic [63:0]  ua, ub, uc, r, q;
    logic [127:0] p;
    bit           neg;
    if (a == 0 || b == 0) return 0;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    uc = (c < 0) ? -c : c;
    neg = ((a < 0) != (b < 0)) != (c < 0);
    p = {64'd0, ua} * {64'd0, ub};
    r = 0;
    q = 0;
    for (int k = 71; k >= 0; k--) begin
      r = {r[62:0], p[k]};
      q = (q >= QuotCap) ? QuotCap : (q << 1);
      if (r >= uc) begin
        r = r - uc;
        if (q < QuotCap) q = q | 64'd1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic int find_interval(longint v, int n);
    int lo, cnt, step, m, idx;
    lo = 0;
    cnt = n;
    while (cnt > 0) begin
      step = cnt / 2;
      m = lo + step;
      if (!(v < knot_xs[m])) begin
        lo = m + 1;
        cnt -= step + 1;
      end else begin
        cnt = step;
      end
    end
    idx = (lo == 0) ? 0 : lo - 1;
    if (idx > n - 2) idx = n - 2;
    return idx;
  endfunction

  function automatic interp_result_t evaluate(longint q);
    interp_result_t r;
    int     n, k;
    longint e, x0, x1, y0, y1, res;
    n = (count_r < 2) ? 2 : ((count_r > MaxKnots) ? MaxKnots : int'(count_r));
    e = q;
    r.reg_code = RegionInside;
    r.sat = 1'b0;
    r.st = StatusOk;
    if (q < knot_xs[0]) begin
      r.reg_code = RegionBelow;
      if (mode_r == ModeFlat) e = knot_xs[0];
      k = find_interval(knot_xs[0], n);
    end else if (q > knot_xs[n-1]) begin
      r.reg_code = RegionAbove;
      if (mode_r == ModeFlat) e = knot_xs[n-1];
      k = find_interval(knot_xs[n-1], n);
    end else begin
      k = find_interval(q, n);
    end
    x0 = knot_xs[k];
    x1 = knot_xs[k+1];
    y0 = knot_ys[k];
    y1 = knot_ys[k+1];
    if (x1 == x0) begin
      res = y1;
      r.st = StatusZeroWidth;
    end else begin
      res = y0 + scaled_quotient(y1 - y0, e - x0, x1 - x0);
      if (res > 64'sh7FFFFFFF) begin res = 64'sh7FFFFFFF; r.sat = 1'b1; end
      if (res < -64'sh80000000) begin res = -64'sh80000000; r.sat = 1'b1; end
      if (r.reg_code != RegionInside && mode_r >= ModeClamp) begin
        if (res < clamp_lo_r) begin res = clamp_lo_r; r.sat = 1'b1; end
        if (res > clamp_hi_r) begin res = clamp_hi_r; r.sat = 1'b1; end
      end
    end
    r.y = res[DataW-1:0];
    r.ivl = k[IdxW-1:0];
    return r;
  endfunction

  assign pending = result_q.size();

  always @(posedge clk) begin
    interp_result_t exp_r, got;
    if (rst) begin
      mode_r <= ModeClamp;
      count_r <= 7'd2;
      clamp_lo_r <= longint'(signed'(ClampLowReset));
      clamp_hi_r <= longint'(signed'(ClampHighReset));
      for (int i = 0; i < MaxKnots; i++) begin
        knot_xs[i] = 0;
        knot_ys[i] = 0;
      end
      result_q.delete();
      errors <= 0;
      n_queries <= 0;
      n_outside <= 0;
      n_zero_width <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegExtrapMode: mode_r <= cfg_data[1:0];
          RegKnotCount:  count_r <= cfg_data[6:0];
          RegClampLow:   clamp_lo_r <= longint'(signed'(cfg_data));
          RegClampHigh:  clamp_hi_r <= longint'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (req_type == ReqWrite) begin
          knot_xs[knot_index] = longint'(knot_x);
          knot_ys[knot_index] = longint'(knot_y);
          exp_r.y = '0;
          exp_r.ivl = knot_index;
          exp_r.reg_code = RegionInside;
          exp_r.sat = 1'b0;
          exp_r.st = StatusWritten;
        end else begin
          exp_r = evaluate(longint'(query_x));
          n_queries <= n_queries + 1;
          if (exp_r.reg_code != RegionInside) n_outside <= n_outside + 1;
          if (exp_r.st == StatusZeroWidth) n_zero_width <= n_zero_width + 1;
        end
        result_q.push_back(exp_r);
      end
      if (out_valid && !out_stall) begin
        got.y = result_y;
        got.ivl = interval;
        got.reg_code = region;
        got.sat = saturated;
        got.st = status;
        if (result_q.size() == 0) begin
          if (errors < 10) $display("unexpected item: y=%h ivl=%0d", result_y, interval);
          errors <= errors + 1;
        end else begin
          exp_r = result_q.pop_front();
          if (got != exp_r) begin
            if (errors < 10)
              $display("mismatch exp y=%h ivl=%0d rg=%0d sat=%0d st=%0d | got y=%h ivl=%0d rg=%0d sat=%0d st=%0d",
                       exp_r.y, exp_r.ivl, exp_r.reg_code, exp_r.sat, exp_r.st,
                       got.y, got.ivl, got.reg_code, got.sat, got.st);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/piecewise_linear_interpolator_test.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_test
// Loads knot tables and queries the interpolator under varied register
// settings, bursty input and a stalling receiver; a checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_test;
  import pli_pkg::*;

  localparam int CycleLimit = 1000000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [1:0]              cfg_index = RegExtrapMode;
  logic [DataW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    req_type = ReqWrite;
  logic [IdxW-1:0]         knot_index = '0;
  logic signed [DataW-1:0] knot_x = '0;
  logic signed [DataW-1:0] knot_y = '0;
  logic signed [DataW-1:0] query_x = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] result_y;
  logic [IdxW-1:0]         interval;
  logic [1:0]              region;
  logic                    saturated;
  logic [1:0]              status;
  int                      errors, pending, n_queries, n_outside, n_zero_width;

  int cycles = 0;
  int burst_left = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_cnt = 0;
  int table_x[MaxKnots];
  int n_used = 2;

  always #1 clk = ~clk;

  piecewise_linear_interpolator u_top (.*);

  pli_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise a rotating stall pattern
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_cnt <= 600;
      out_stall <= 1'b1;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      case ((cycles / 97) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycles[3];
      endcase
    end
  end

  task automatic send(input logic rt, input logic [IdxW-1:0] ki, input int kx, input int ky,
                      input int qx);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    knot_index <= ki;
    knot_x <= kx;
    knot_y <= ky;
    query_x <= qx;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    burst_left--;
  endtask

  task automatic write_knot(input int i, input int x, input int y);
    if (i < MaxKnots) table_x[i] = x;
    send(ReqWrite, i[IdxW-1:0], x, y, int'($urandom));
  endtask

  task automatic query(input int qx);
    send(~ReqWrite, 6'($urandom), int'($urandom), int'($urandom), qx);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_regs(input logic [1:0] mode, input logic [6:0] cnt, input int lo,
                          input int hi);
    cfg_we <= 1'b1;
    cfg_index <= RegExtrapMode;
    cfg_data <= {30'($urandom), mode};
    @(posedge clk);
    cfg_index <= RegKnotCount;
    cfg_data <= {25'($urandom), cnt};
    @(posedge clk);
    cfg_index <= RegClampLow;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= RegClampHigh;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_used = (cnt < 2) ? 2 : ((cnt > MaxKnots) ? MaxKnots : int'(cnt));
  endtask

  // ascending table over the used knots, sometimes with repeated abscissas
  task automatic load_sorted(input int n);
    longint x, stepmax;
    bit wide;
    wide = $urandom_range(0, 1);
    stepmax = wide ? 66000000 : 300000;
    x = wide ? -64'sd2147483648 + $urandom_range(0, 1 << 20)
             : longint'($urandom_range(0, 2000000)) - 1000000;
    for (int i = 0; i < n; i++) begin
      write_knot(i, int'(x), ($urandom_range(0, 2) == 0) ? int'($urandom)
                             : int'($urandom_range(0, 1 << 20)) - (1 << 19));
      x += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, int'(stepmax));
    end
  endtask

  function automatic int pick_query();
    int lo, hi;
    lo = table_x[0];
    hi = table_x[n_used-1];
    case ($urandom_range(0, 7))
      0: return int'($urandom);
      1: return table_x[$urandom_range(0, n_used - 1)];
      2: return lo - int'($urandom_range(1, 1 << 22));
      3: return hi + int'($urandom_range(1, 1 << 22));
      4: return ($urandom_range(0, 1) == 0) ? 32'sh80000000 : 32'sh7FFFFFFF;
      default: begin
        if (hi <= lo) return lo;
        return int'(longint'(lo) + longint'($urandom_range(0, int'(hi - lo))));
      end
    endcase
  endfunction

  initial begin
    int mode, cnt, lo, hi;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the whole table so no query ever reads an unwritten knot
    for (int i = 0; i < MaxKnots; i++) write_knot(i, (i - 32) << 16, i * i * 1000);
    query(32'sh80000000);
    query(32'sh7FFFFFFF);
    query(table_x[0]);
    query(table_x[1]);
    query(table_x[0] + 100);
    drain();
    set_regs(ModeLinear, 7'd64, 32'sh80000000, 32'sh7FFFFFFF);
    query(32'sh80000000);
    query(32'sh7FFFFFFF);
    query(table_x[63]);
    query(5 << 15);
    drain();
    set_regs(ModeFlat, 7'd64, 0, 0);
    query(32'sh80000000);
    query(32'sh7FFFFFFF);
    write_knot(0, 32'sh80000000, 32'sh7FFFFFFF);
    write_knot(1, 32'sh7FFFFFFF, 32'sh80000000);
    query(0);
    write_knot(1, 32'sh80000000, 123);
    query(32'sh80000000);
    query(-1);
    drain();
    set_regs(2'd3, 7'd0, 32'sh7FFFFFFF, 32'sh80000000);
    query(32'sh80000000);
    query(32'sh7FFFFFFF);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      mode = $urandom_range(0, 3);
      case (ph % 5)
        0: cnt = 2;
        1: cnt = 64;
        2: cnt = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(65, 127);
        default: cnt = $urandom_range(2, 64);
      endcase
      case (ph % 4)
        0: begin lo = 32'sh80000000; hi = 32'sh7FFFFFFF; end
        1: begin lo = 32'sh7FFFFFFF; hi = 32'sh80000000; end
        2: begin lo = 0; hi = 0; end
        default: begin lo = int'($urandom); hi = int'($urandom); end
      endcase
      set_regs(mode[1:0], cnt[6:0], lo, hi);
      load_sorted(n_used);
      if (ph == 4) hold_seq <= hold_seq + 1;
      for (int j = 0; j < 16; j++) begin
        case ($urandom_range(0, 9))
          0: write_knot($urandom_range(0, 63), int'($urandom), int'($urandom));
          1: write_knot($urandom_range(0, n_used - 1), pick_query(), int'($urandom));
          default: query(pick_query());
        endcase
      end
      drain();
    end

    drain();
    $display("covered %0d queries, %0d outside the knot range, %0d zero-width intervals",
             n_queries, n_outside, n_zero_width);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
